@@ rtl/ecr_pkg.sv @@
package ecr_pkg;

   // Widths fixed by the interface fields.
   localparam int VAL_W = 40;
   localparam int FIELD_W = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CHAN_OUT_W = 8;
   localparam int NBANDS = 6;

   // Parameter defaults.
   localparam int FRAC_BITS_DEFAULT = 8;
   localparam int COLOR_BITS_DEFAULT = 8;

   // One foot in Q24.8, the base of the depth ramp span.
   localparam logic signed [VAL_W-1:0] ONE_FOOT = 40'sd256;

   // Mode codes.
   localparam logic [2:0] MODE_LAND = 3'd0;
   localparam logic [2:0] MODE_GRAY_CLAMPED = 3'd1;
   localparam logic [2:0] MODE_GRAY_RAW = 3'd2;
   localparam logic [2:0] MODE_BINARY = 3'd3;
   localparam logic [2:0] MODE_DEPTH = 3'd4;
   localparam logic [2:0] MODE_DEPTH_WATER = 3'd5;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_LAND = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_VALUE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NODATA = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEW_WATER = 3'd4;

   localparam logic signed [FIELD_W-1:0] NODATA_RESET = -32'sd2559744;
   localparam logic signed [FIELD_W-1:0] NEW_WATER_RESET = -32'sd2559488;

   typedef enum logic [1:0] {
      RAMP_LAND  = 2'd0,
      RAMP_GRAY  = 2'd1,
      RAMP_BLUE  = 2'd2,
      RAMP_FIXED = 2'd3
   } ramp_sel_type;

   typedef enum logic [1:0] {
      COLOR_BLACK      = 2'd0,
      COLOR_DARK_BLUE  = 2'd1,
      COLOR_LIGHT_BLUE = 2'd2
   } color_type;

   // Which color table, which band, and which fixed color an item uses.
   typedef struct packed {
      ramp_sel_type ramp;
      color_type    color;
      logic [2:0]   band;
   } info_type;

   // Configuration register file as seen by the datapath.
   typedef struct packed {
      logic [2:0]                mode;
      logic signed [FIELD_W-1:0] min_land;
      logic signed [FIELD_W-1:0] max_value;
      logic signed [FIELD_W-1:0] no_data_mark;
      logic signed [FIELD_W-1:0] new_water_value;
   } cfg_type;

   // Divider stage contents, apart from the partial quotient.
   typedef struct packed {
      logic             valid;
      logic             done;
      logic [VAL_W-1:0] rem;
      logic [VAL_W-1:0] span;
      info_type         info;
   } div_type;

   // Stock colors in thousandths.
   localparam int LAND_MILLI [7][3] = '{
      '{945, 1000, 905}, '{749, 918, 737}, '{561, 839, 580}, '{424, 682, 459},
      '{545, 580, 455}, '{298, 298, 278}, '{188, 212, 200}};
   localparam int GRAY_MILLI [7][3] = '{
      '{949, 949, 949}, '{729, 729, 729}, '{518, 518, 518}, '{349, 349, 349},
      '{196, 196, 196}, '{118, 118, 118}, '{0, 0, 0}};
   localparam int BLUE_MILLI [7][3] = '{
      '{305, 486, 553}, '{380, 568, 619}, '{455, 655, 690}, '{529, 737, 756},
      '{572, 784, 800}, '{568, 776, 792}, '{604, 820, 831}};
   localparam int FIXED_MILLI [3][3] = '{
      '{0, 0, 0}, '{157, 325, 419}, '{604, 820, 831}};

   // Thousandths to a channel of the given width, rounded half up.
   function automatic int to_chan(input int milli, input int cbits);
      int cmax;
      cmax = (1 << cbits) - 1;
      return (milli * cmax + 500) / 1000;
   endfunction

   function automatic logic signed [VAL_W-1:0] sext(input logic signed [FIELD_W-1:0] x);
      return VAL_W'(x);
   endfunction

endpackage

@@ rtl/elevation_color_ramp_unit.sv @@
// Elevation color ramp: turns one Q24.8 elevation sample and its local water
// level into an 8-bit RGB color, one request per clock with no gaps while
// rsp_stall does not hold the output. A request passes through 7 + FRAC_BITS
// register stages (15 at the default), most of them set by the band-fraction
// divider, which produces one quotient bit per pipeline stage. The whole
// pipeline holds while a result waits under rsp_stall, so req_stall follows it.
// The user must write registers through csr_* only while no request is in
// flight; the block does not enforce it.
module elevation_color_ramp_unit #(
   parameter int FRAC_BITS = ecr_pkg::FRAC_BITS_DEFAULT,
   parameter int COLOR_BITS = ecr_pkg::COLOR_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [ecr_pkg::FIELD_W-1:0]     req_elevation,
   input  logic signed [ecr_pkg::FIELD_W-1:0]     req_water_level,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [ecr_pkg::CHAN_OUT_W-1:0]         rsp_red,
   output logic [ecr_pkg::CHAN_OUT_W-1:0]         rsp_green,
   output logic [ecr_pkg::CHAN_OUT_W-1:0]         rsp_blue_level,
   input  logic                                   csr_write_en,
   input  logic [ecr_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [ecr_pkg::FIELD_W-1:0]            csr_data
);

   localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

   // Configuration registers.
   ecr_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode <= ecr_pkg::MODE_LAND;
         cfg_ff.min_land <= '0;
         cfg_ff.max_value <= '0;
         cfg_ff.no_data_mark <= ecr_pkg::NODATA_RESET;
         cfg_ff.new_water_value <= ecr_pkg::NEW_WATER_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            ecr_pkg::CSR_MODE:      cfg_ff.mode <= csr_data[2:0];
            ecr_pkg::CSR_MIN_LAND:  cfg_ff.min_land <= csr_data;
            ecr_pkg::CSR_MAX_VALUE: cfg_ff.max_value <= csr_data;
            ecr_pkg::CSR_NODATA:    cfg_ff.no_data_mark <= csr_data;
            ecr_pkg::CSR_NEW_WATER: cfg_ff.new_water_value <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // The pipeline moves whenever the output register is free or being taken.
   logic adv;
   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   ecr_pkg::div_type   div_chain [FRAC_BITS+1];
   logic [FRAC_BITS:0] q_chain [FRAC_BITS+1];

   ecr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock(clock),
      .reset(reset),
      .adv(adv),
      .in_valid(req_valid),
      .elevation(req_elevation),
      .water_level(req_water_level),
      .cfg(cfg_ff),
      .div_out(div_chain[0]),
      .q_out(q_chain[0])
   );

   for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
      ecr_div_step #(.FRAC_BITS(FRAC_BITS)) u_step (
         .clock(clock),
         .reset(reset),
         .adv(adv),
         .div_in(div_chain[i]),
         .q_prev(q_chain[i]),
         .div_out(div_chain[i+1]),
         .q_out(q_chain[i+1])
      );
   end

   ecr_back #(.FRAC_BITS(FRAC_BITS), .COLOR_BITS(COLOR_BITS)) u_back (
      .clock(clock),
      .reset(reset),
      .adv(adv),
      .in_valid(div_chain[FRAC_BITS].valid),
      .t(q_chain[FRAC_BITS]),
      .info(div_chain[FRAC_BITS].info),
      .out_valid(rsp_valid),
      .red(rsp_red),
      .green(rsp_green),
      .blue_level(rsp_blue_level)
   );

`ifndef NO_ASSERTIONS
   // The band fraction never exceeds one after the divider.
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      div_chain[FRAC_BITS].valid |-> q_chain[FRAC_BITS] <= ONE)
      else $error("band fraction above one");

   // A ramped item always lands in one of the six bands.
   a_band_range: assert property (@(posedge clock) disable iff (reset)
      (div_chain[FRAC_BITS].valid && div_chain[FRAC_BITS].info.ramp != ecr_pkg::RAMP_FIXED)
      |-> div_chain[FRAC_BITS].info.band <= 3'd5)
      else $error("band index out of range");

   // A finished divide has no remainder left at or above the span.
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (div_chain[FRAC_BITS].valid && !div_chain[FRAC_BITS].done)
      |-> div_chain[FRAC_BITS].rem < div_chain[FRAC_BITS].span)
      else $error("divider remainder not reduced");
`endif

endmodule

@@ rtl/ecr_front.sv @@
module ecr_front #(
   parameter int FRAC_BITS = ecr_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               in_valid,
   input  logic signed [ecr_pkg::FIELD_W-1:0] elevation,
   input  logic signed [ecr_pkg::FIELD_W-1:0] water_level,
   input  ecr_pkg::cfg_type                   cfg,
   output ecr_pkg::div_type                   div_out,
   output logic [FRAC_BITS:0]                 q_out
);

   localparam int W = ecr_pkg::VAL_W;
   localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

   // Stage 1: mode decode, ramp offset and span.
   logic                s1_valid_ff, s1_valid_in;
   logic signed [W-1:0] s1_d_ff, s1_d_in;
   logic signed [W-1:0] s1_span_ff, s1_span_in;
   ecr_pkg::info_type   s1_info_ff, s1_info_in;

   logic signed [W-1:0] v_e, lo_e, shift_e;

   always_comb begin
      v_e = ecr_pkg::sext(elevation);
      shift_e = ecr_pkg::sext(water_level) - ecr_pkg::sext(cfg.min_land);
      lo_e = ecr_pkg::sext(cfg.min_land);
      if (cfg.mode != ecr_pkg::MODE_GRAY_RAW && cfg.min_land < 0) begin
         lo_e = '0;
      end
      s1_valid_in = in_valid;
      s1_d_in = '0;
      s1_span_in = '0;
      s1_info_in.ramp = ecr_pkg::RAMP_FIXED;
      s1_info_in.color = ecr_pkg::COLOR_BLACK;
      s1_info_in.band = '0;
      unique case (cfg.mode)
         ecr_pkg::MODE_LAND, ecr_pkg::MODE_GRAY_CLAMPED, ecr_pkg::MODE_GRAY_RAW: begin
            if (elevation == cfg.no_data_mark) begin
               s1_info_in.color = ecr_pkg::COLOR_DARK_BLUE;
            end else if (elevation == cfg.new_water_value) begin
               s1_info_in.color = ecr_pkg::COLOR_LIGHT_BLUE;
            end else begin
               s1_info_in.ramp = (cfg.mode == ecr_pkg::MODE_LAND) ?
                                 ecr_pkg::RAMP_LAND : ecr_pkg::RAMP_GRAY;
               s1_d_in = v_e - lo_e;
               s1_span_in = ecr_pkg::sext(cfg.max_value) - lo_e;
            end
         end
         ecr_pkg::MODE_BINARY: begin
            if (elevation == '0) begin
               s1_info_in.color = ecr_pkg::COLOR_DARK_BLUE;
            end
         end
         ecr_pkg::MODE_DEPTH, ecr_pkg::MODE_DEPTH_WATER: begin
            if (elevation > 0) begin
               s1_info_in.color = ecr_pkg::COLOR_BLACK;
            end else if (elevation == cfg.no_data_mark) begin
               if (cfg.mode == ecr_pkg::MODE_DEPTH_WATER) begin
                  s1_info_in.color = ecr_pkg::COLOR_DARK_BLUE;
               end
            end else begin
               s1_info_in.ramp = ecr_pkg::RAMP_BLUE;
               s1_d_in = v_e + shift_e;
               s1_span_in = ecr_pkg::ONE_FOOT + shift_e;
            end
         end
         default: begin
            s1_info_in.color = ecr_pkg::COLOR_BLACK;
         end
      endcase
   end

   // Stage 2: six times the offset and the band boundary multiples.
   logic                s2_valid_ff;
   logic signed [W-1:0] s2_sixd_ff, s2_sixd_in;
   logic signed [W-1:0] s2_mul_ff [1:5];
   logic signed [W-1:0] s2_mul_in [1:5];
   ecr_pkg::info_type   s2_info_ff;

   always_comb begin
      s2_sixd_in = (s1_d_ff <<< 2) + (s1_d_ff <<< 1);
      s2_mul_in[1] = s1_span_ff;
      s2_mul_in[2] = s1_span_ff <<< 1;
      s2_mul_in[3] = s1_span_ff + (s1_span_ff <<< 1);
      s2_mul_in[4] = s1_span_ff <<< 2;
      s2_mul_in[5] = s1_span_ff + (s1_span_ff <<< 2);
   end

   // Stage 3: pick the first band whose upper boundary lies above the value.
   logic                s3_valid_ff;
   logic signed [W-1:0] s3_sixd_ff, s3_span_ff;
   logic signed [W-1:0] s3_kspan_ff, s3_kspan_in;
   ecr_pkg::info_type   s3_info_ff, s3_info_in;

   always_comb begin
      s3_info_in = s2_info_ff;
      s3_info_in.band = 3'd5;
      s3_kspan_in = s2_mul_ff[5];
      priority if (s2_sixd_ff < s2_mul_ff[1]) begin
         s3_info_in.band = 3'd0;
         s3_kspan_in = '0;
      end else if (s2_sixd_ff < s2_mul_ff[2]) begin
         s3_info_in.band = 3'd1;
         s3_kspan_in = s2_mul_ff[1];
      end else if (s2_sixd_ff < s2_mul_ff[3]) begin
         s3_info_in.band = 3'd2;
         s3_kspan_in = s2_mul_ff[2];
      end else if (s2_sixd_ff < s2_mul_ff[4]) begin
         s3_info_in.band = 3'd3;
         s3_kspan_in = s2_mul_ff[3];
      end else if (s2_sixd_ff < s2_mul_ff[5]) begin
         s3_info_in.band = 3'd4;
         s3_kspan_in = s2_mul_ff[4];
      end else begin
         s3_info_in.band = 3'd5;
         s3_kspan_in = s2_mul_ff[5];
      end
   end

   // Stage 4: numerator inside the band and the saturation cases.
   ecr_pkg::div_type    div_ff, div_in;
   logic [FRAC_BITS:0]  q_ff, q_in;
   logic signed [W-1:0] num;

   always_comb begin
      num = s3_sixd_ff - s3_kspan_ff;
      div_in.valid = s3_valid_ff;
      div_in.info = s3_info_ff;
      div_in.span = s3_span_ff;
      div_in.rem = num;
      div_in.done = 1'b1;
      q_in = '0;
      priority if (s3_info_ff.ramp == ecr_pkg::RAMP_FIXED || s3_span_ff <= 0 || num <= 0) begin
         q_in = '0;
      end else if (num >= s3_span_ff) begin
         q_in = ONE;
      end else begin
         div_in.done = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         div_ff.valid <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         div_ff.valid <= div_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_d_ff <= s1_d_in;
         s1_span_ff <= s1_span_in;
         s1_info_ff <= s1_info_in;
         s2_sixd_ff <= s2_sixd_in;
         s2_mul_ff <= s2_mul_in;
         s2_info_ff <= s1_info_ff;
         s3_sixd_ff <= s2_sixd_ff;
         s3_span_ff <= s2_mul_ff[1];
         s3_kspan_ff <= s3_kspan_in;
         s3_info_ff <= s3_info_in;
         div_ff.done <= div_in.done;
         div_ff.rem <= div_in.rem;
         div_ff.span <= div_in.span;
         div_ff.info <= div_in.info;
         q_ff <= q_in;
      end
   end

   assign div_out = div_ff;
   assign q_out = q_ff;

endmodule

@@ rtl/ecr_div_step.sv @@
module ecr_div_step #(
   parameter int FRAC_BITS = ecr_pkg::FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  ecr_pkg::div_type   div_in,
   input  logic [FRAC_BITS:0] q_prev,
   output ecr_pkg::div_type   div_out,
   output logic [FRAC_BITS:0] q_out
);

   localparam int W = ecr_pkg::VAL_W;

   ecr_pkg::div_type   div_ff;
   logic [FRAC_BITS:0] q_ff, q_in;
   logic [W-1:0]       rem2, rem_in;
   logic               ge;

   // One restoring step: one quotient bit per stage.
   always_comb begin
      rem2 = {div_in.rem[W-2:0], 1'b0};
      ge = !div_in.done && (rem2 >= div_in.span);
      rem_in = ge ? (rem2 - div_in.span) : rem2;
      q_in = div_in.done ? q_prev : {q_prev[FRAC_BITS-1:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff.valid <= 1'b0;
      end else if (adv) begin
         div_ff.valid <= div_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff.done <= div_in.done;
         div_ff.rem <= rem_in;
         div_ff.span <= div_in.span;
         div_ff.info <= div_in.info;
         q_ff <= q_in;
      end
   end

   assign div_out = div_ff;
   assign q_out = q_ff;

endmodule

@@ rtl/ecr_back.sv @@
module ecr_back #(
   parameter int FRAC_BITS = ecr_pkg::FRAC_BITS_DEFAULT,
   parameter int COLOR_BITS = ecr_pkg::COLOR_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                in_valid,
   input  logic [FRAC_BITS:0]                  t,
   input  ecr_pkg::info_type                   info,
   output logic                                out_valid,
   output logic [ecr_pkg::CHAN_OUT_W-1:0]      red,
   output logic [ecr_pkg::CHAN_OUT_W-1:0]      green,
   output logic [ecr_pkg::CHAN_OUT_W-1:0]      blue_level
);

   localparam int CB = COLOR_BITS;
   localparam int CMAX = (1 << CB) - 1;
   localparam int AW = CB + FRAC_BITS + 3;
   localparam int HALF = (1 << FRAC_BITS) >> 1;
   localparam int XW = CB + 9;
   localparam int SH = XW;
   localparam int MW = XW - CB + 2;
   localparam logic [MW-1:0] RECIP = MW'((64'd1 << SH) / CMAX);
   localparam int OW = ecr_pkg::CHAN_OUT_W;

   // Stock colors at channel width, folded at elaboration.
   logic [CB-1:0] tab_land  [7][3];
   logic [CB-1:0] tab_gray  [7][3];
   logic [CB-1:0] tab_blue  [7][3];
   logic [CB-1:0] tab_fixed [3][3];

   for (genvar k = 0; k < 7; k++) begin : g_tab
      for (genvar c = 0; c < 3; c++) begin : g_ch
         assign tab_land[k][c] = CB'(ecr_pkg::to_chan(ecr_pkg::LAND_MILLI[k][c], CB));
         assign tab_gray[k][c] = CB'(ecr_pkg::to_chan(ecr_pkg::GRAY_MILLI[k][c], CB));
         assign tab_blue[k][c] = CB'(ecr_pkg::to_chan(ecr_pkg::BLUE_MILLI[k][c], CB));
      end
   end
   for (genvar k = 0; k < 3; k++) begin : g_fix
      for (genvar c = 0; c < 3; c++) begin : g_ch
         assign tab_fixed[k][c] = CB'(ecr_pkg::to_chan(ecr_pkg::FIXED_MILLI[k][c], CB));
      end
   end

   // Stage 1: linear blend between the band's end colors.
   logic          b1_valid_ff;
   logic [CB-1:0] b1_v_ff [3];
   logic [CB-1:0] b1_v_in [3];
   logic [CB-1:0] lo [3];
   logic [CB-1:0] hi [3];
   logic signed [AW-1:0] lo_e [3];
   logic signed [AW-1:0] hi_e [3];
   logic signed [AW-1:0] acc [3];
   logic signed [AW-1:0] t_e;
   logic [2:0]    band_hi;

   always_comb begin
      t_e = AW'(t);
      band_hi = info.band + 3'd1;
      for (int c = 0; c < 3; c++) begin
         unique case (info.ramp)
            ecr_pkg::RAMP_LAND: begin
               lo[c] = tab_land[info.band][c];
               hi[c] = tab_land[band_hi][c];
            end
            ecr_pkg::RAMP_GRAY: begin
               lo[c] = tab_gray[info.band][c];
               hi[c] = tab_gray[band_hi][c];
            end
            ecr_pkg::RAMP_BLUE: begin
               lo[c] = tab_blue[info.band][c];
               hi[c] = tab_blue[band_hi][c];
            end
            ecr_pkg::RAMP_FIXED: begin
               lo[c] = tab_fixed[info.color][c];
               hi[c] = tab_fixed[info.color][c];
            end
            default: begin
               lo[c] = '0;
               hi[c] = '0;
            end
         endcase
         lo_e[c] = AW'(lo[c]);
         hi_e[c] = AW'(hi[c]);
         acc[c] = (lo_e[c] <<< FRAC_BITS) + (hi_e[c] - lo_e[c]) * t_e + AW'(HALF);
         b1_v_in[c] = acc[c][FRAC_BITS +: CB];
      end
   end

   // Stage 2: rescale to eight bits, quotient estimate by reciprocal.
   logic          b2_valid_ff;
   logic [XW-1:0] b2_x_ff [3];
   logic [XW-1:0] b2_x_in [3];
   logic [OW-1:0] b2_q_ff [3];
   logic [OW-1:0] b2_q_in [3];
   logic [XW+MW-1:0] prod [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         b2_x_in[c] = XW'(b1_v_ff[c]) * XW'(255) + XW'(CMAX / 2);
         prod[c] = (XW+MW)'(b2_x_in[c]) * (XW+MW)'(RECIP);
         b2_q_in[c] = prod[c][SH +: OW];
      end
   end

   // Stage 3: the estimate is at most one low; correct it.
   logic [OW-1:0] b3_c_ff [3];
   logic [OW-1:0] b3_c_in [3];
   logic [XW-1:0] rem [3];
   logic          b3_valid_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rem[c] = b2_x_ff[c] - XW'(b2_q_ff[c]) * XW'(CMAX);
         b3_c_in[c] = (rem[c] >= XW'(CMAX)) ? (b2_q_ff[c] + OW'(1)) : b2_q_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
      end else if (adv) begin
         b1_valid_ff <= in_valid;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_v_ff <= b1_v_in;
         b2_x_ff <= b2_x_in;
         b2_q_ff <= b2_q_in;
         b3_c_ff <= b3_c_in;
      end
   end

   assign out_valid = b3_valid_ff;
   assign red = b3_c_ff[0];
   assign green = b3_c_ff[1];
   assign blue_level = b3_c_ff[2];

endmodule

@@ tb/tb_elevation_color_ramp_unit.sv @@
module tb_elevation_color_ramp_unit;
   timeunit 1ns;
   timeprecision 1ps;

   // Mode code with no defined coloring.
   localparam logic [2:0] UNDEFINED_MODE = 3'd6;

   typedef struct {
      logic signed [31:0] elevation;
      logic signed [31:0] water_level;
   } sample_type;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue_level;
   } rgb_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_elevation = '0;
   logic signed [31:0] req_water_level = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_red, rsp_green, rsp_blue_level;
   logic csr_write_en = 1'b0;
   logic [2:0] csr_index = ecr_pkg::CSR_MODE;
   logic [31:0] csr_data = '0;

   elevation_color_ramp_unit dut (.*);

   // Register shadow used by the color predictor.
   logic [2:0] sh_mode = ecr_pkg::MODE_LAND;
   longint sh_min_land = 0;
   longint sh_max_value = 0;
   longint sh_nodata = longint'(ecr_pkg::NODATA_RESET);
   longint sh_new_water = longint'(ecr_pkg::NEW_WATER_RESET);

   sample_type pending_samples[$];
   rgb_type expected_colors[$];
   int errors = 0;
   int n_requests = 0;
   int n_colors = 0;
   int n_settings = 0;
   bit [7:0] modes_seen = '0;

   initial begin
      forever #4 clock = ~clock;
   end

   // Thousandths to an 8-bit channel, rounded half up.
   function automatic longint milli_to_chan(input int milli);
      return (longint'(milli) * 255 + 500) / 1000;
   endfunction

   function automatic rgb_type fixed_color(input ecr_pkg::color_type idx);
      rgb_type c;
      c.red = 8'(milli_to_chan(ecr_pkg::FIXED_MILLI[idx][0]));
      c.green = 8'(milli_to_chan(ecr_pkg::FIXED_MILLI[idx][1]));
      c.blue_level = 8'(milli_to_chan(ecr_pkg::FIXED_MILLI[idx][2]));
      return c;
   endfunction

   // Six-band blend over the chosen stock ramp; d and span are offsets from the low end.
   function automatic rgb_type blend_bands(input ecr_pkg::ramp_sel_type ramp_id,
                                           input longint d, input longint span);
      int k;
      longint num, t, lo, hi, acc;
      longint unsigned q;
      longint ch[3];
      int milli_lo, milli_hi;
      rgb_type c;
      k = 5;
      for (int b = 0; b < 5; b++) begin
         if (6 * d < longint'(b + 1) * span) begin
            k = b;
            break;
         end
      end
      num = 6 * d - longint'(k) * span;
      t = 0;
      if (span > 0 && num > 0) begin
         q = (longint'(num) << 8) / span;
         t = (q > 256) ? 256 : longint'(q);
      end
      for (int i = 0; i < 3; i++) begin
         case (ramp_id)
            ecr_pkg::RAMP_LAND: begin
               milli_lo = ecr_pkg::LAND_MILLI[k][i];
               milli_hi = ecr_pkg::LAND_MILLI[k+1][i];
            end
            ecr_pkg::RAMP_GRAY: begin
               milli_lo = ecr_pkg::GRAY_MILLI[k][i];
               milli_hi = ecr_pkg::GRAY_MILLI[k+1][i];
            end
            default: begin
               milli_lo = ecr_pkg::BLUE_MILLI[k][i];
               milli_hi = ecr_pkg::BLUE_MILLI[k+1][i];
            end
         endcase
         lo = milli_to_chan(milli_lo);
         hi = milli_to_chan(milli_hi);
         acc = lo * 256 + (hi - lo) * t + 128;
         ch[i] = acc >>> 8;
      end
      c.red = 8'(ch[0]);
      c.green = 8'(ch[1]);
      c.blue_level = 8'(ch[2]);
      return c;
   endfunction

   function automatic rgb_type predict_color(input sample_type s);
      longint v, w, lo, shift;
      v = longint'(s.elevation);
      w = longint'(s.water_level);
      case (sh_mode)
         ecr_pkg::MODE_LAND, ecr_pkg::MODE_GRAY_CLAMPED, ecr_pkg::MODE_GRAY_RAW: begin
            if (v == sh_nodata) return fixed_color(ecr_pkg::COLOR_DARK_BLUE);
            if (v == sh_new_water) return fixed_color(ecr_pkg::COLOR_LIGHT_BLUE);
            lo = sh_min_land;
            if (sh_mode != ecr_pkg::MODE_GRAY_RAW && lo < 0) lo = 0;
            return blend_bands(sh_mode == ecr_pkg::MODE_LAND ?
                               ecr_pkg::RAMP_LAND : ecr_pkg::RAMP_GRAY,
                               v - lo, sh_max_value - lo);
         end
         ecr_pkg::MODE_BINARY:
            return fixed_color(v == 0 ? ecr_pkg::COLOR_DARK_BLUE : ecr_pkg::COLOR_BLACK);
         ecr_pkg::MODE_DEPTH, ecr_pkg::MODE_DEPTH_WATER: begin
            if (v > 0) return fixed_color(ecr_pkg::COLOR_BLACK);
            if (v == sh_nodata)
               return fixed_color(sh_mode == ecr_pkg::MODE_DEPTH_WATER ?
                                  ecr_pkg::COLOR_DARK_BLUE : ecr_pkg::COLOR_BLACK);
            shift = w - sh_min_land;
            return blend_bands(ecr_pkg::RAMP_BLUE, v + shift, 256 + shift);
         end
         default:
            return fixed_color(ecr_pkg::COLOR_BLACK);
      endcase
   endfunction

   // Request driver: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   sample_type driven;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_colors.push_back(predict_color(driven));
            n_requests++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               driven = pending_samples.pop_front();
               req_valid <= 1'b1;
               req_elevation <= driven.elevation;
               req_water_level <= driven.water_level;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and stall pattern, with one long hold-off to fill the pipeline.
   int stall_style = 0;
   int style_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin
      rgb_type exp_c;
      bit stall_next;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            n_colors++;
            if (expected_colors.size() == 0) begin
               $display("%0t: unexpected color %h %h %h", $realtime,
                        rsp_red, rsp_green, rsp_blue_level);
               errors++;
            end else begin
               exp_c = expected_colors.pop_front();
               if (rsp_red !== exp_c.red) begin
                  $display("%0t: red expected %h actual %h", $realtime, exp_c.red, rsp_red);
                  errors++;
               end
               if (rsp_green !== exp_c.green) begin
                  $display("%0t: green expected %h actual %h", $realtime, exp_c.green,
                           rsp_green);
                  errors++;
               end
               if (rsp_blue_level !== exp_c.blue_level) begin
                  $display("%0t: blue expected %h actual %h", $realtime, exp_c.blue_level,
                           rsp_blue_level);
                  errors++;
               end
            end
         end
         if (!hold_done && n_requests >= 150) begin
            hold_done = 1'b1;
            hold_left = 300;
         end
         if (style_left == 0) begin
            style_left = $urandom_range(20, 80);
            stall_style = $urandom_range(0, 3);
         end else begin
            style_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else begin
            case (stall_style)
               0: stall_next = 1'b0;
               1: stall_next = ($urandom_range(0, 9) == 0);
               2: stall_next = ($urandom_range(0, 1) == 0);
               default: stall_next = ($urandom_range(0, 9) != 0);
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   // Watchdog on cycles with no handshake on either channel.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= 5000) begin
         $display("%0t: timeout with %0d colors outstanding", $realtime,
                  expected_colors.size());
         $display("** elevation_color_ramp_unit: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_colors.size() != 0);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      case (idx)
         ecr_pkg::CSR_MODE: sh_mode = val[2:0];
         ecr_pkg::CSR_MIN_LAND: sh_min_land = longint'($signed(val));
         ecr_pkg::CSR_MAX_VALUE: sh_max_value = longint'($signed(val));
         ecr_pkg::CSR_NODATA: sh_nodata = longint'($signed(val));
         default: sh_new_water = longint'($signed(val));
      endcase
   endtask

   task automatic configure(input logic [2:0] m, input int mn, input int mx,
                            input int nd, input int nw);
      wait_idle();
      write_reg(ecr_pkg::CSR_MODE, m);
      write_reg(ecr_pkg::CSR_MIN_LAND, mn);
      write_reg(ecr_pkg::CSR_MAX_VALUE, mx);
      write_reg(ecr_pkg::CSR_NODATA, nd);
      write_reg(ecr_pkg::CSR_NEW_WATER, nw);
      @(posedge clock);
      csr_write_en <= 1'b0;
      n_settings++;
      modes_seen[m] = 1'b1;
   endtask

   task automatic add_sample(input int e, input int w);
      sample_type s;
      s.elevation = e;
      s.water_level = w;
      pending_samples.push_back(s);
   endtask

   function automatic int pick_elevation();
      int span;
      span = int'(sh_max_value - sh_min_land);
      if (span < 0 || span > 200000) span = 200000;
      case ($urandom_range(0, 11))
         0: return int'(sh_nodata);
         1: return int'(sh_new_water);
         2: return 0;
         3: return $urandom;
         4: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
         5: return -int'($urandom_range(0, 3000));
         default: return int'(sh_min_land) + int'($urandom_range(0, span + 2000)) - 1000;
      endcase
   endfunction

   function automatic int pick_water();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
         default: return int'(sh_min_land) + int'($urandom_range(0, 4000)) - 500;
      endcase
   endfunction

   initial begin
      int mn, mx, nd, nw;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: empty land range, then both sentinels.
      add_sample(32'sh7fffffff, 0);
      add_sample(ecr_pkg::NODATA_RESET, 0);
      add_sample(ecr_pkg::NEW_WATER_RESET, 0);
      add_sample(32'sh80000000, 32'sh7fffffff);

      // Land ramp across every band, below and above the range.
      configure(ecr_pkg::MODE_LAND, -512, 6 * 2560, ecr_pkg::NODATA_RESET,
                ecr_pkg::NEW_WATER_RESET);
      for (int i = -1; i <= 7; i++) add_sample(i * 2560 + 1000, 0);
      // Gray raw with a positive minimum and a reversed range.
      configure(ecr_pkg::MODE_GRAY_RAW, 1000, -5000, ecr_pkg::NODATA_RESET,
                ecr_pkg::NEW_WATER_RESET);
      add_sample(-2000, 0);
      add_sample(3000, 0);
      // Gray clamped with colliding sentinels: no-data wins.
      configure(ecr_pkg::MODE_GRAY_CLAMPED, -9000, 9000, 77, 77);
      add_sample(77, 0);
      add_sample(4500, 0);
      // Binary, zero and nonzero.
      configure(ecr_pkg::MODE_BINARY, 0, 0, ecr_pkg::NODATA_RESET,
                ecr_pkg::NEW_WATER_RESET);
      add_sample(0, 0);
      add_sample(-1, 0);
      // Depth modes: above water, no-data, and in range.
      configure(ecr_pkg::MODE_DEPTH, 1000, 0, ecr_pkg::NODATA_RESET,
                ecr_pkg::NEW_WATER_RESET);
      add_sample(5, 1200);
      add_sample(ecr_pkg::NODATA_RESET, 1200);
      add_sample(-100, 1200);
      configure(ecr_pkg::MODE_DEPTH_WATER, 1000, 0, ecr_pkg::NODATA_RESET,
                ecr_pkg::NEW_WATER_RESET);
      add_sample(ecr_pkg::NODATA_RESET, 1200);
      add_sample(0, 32'sh80000000);
      // Undefined mode.
      configure(UNDEFINED_MODE, 0, 0, ecr_pkg::NODATA_RESET, ecr_pkg::NEW_WATER_RESET);
      add_sample(1234, 0);

      // Random phases, each with its own register setting.
      for (int p = 0; p < 12; p++) begin
         case ($urandom_range(0, 5))
            0: mn = -int'($urandom_range(0, 5000));
            1: mn = $urandom;
            2: mn = ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
            default: mn = int'($urandom_range(0, 20000)) - 2000;
         endcase
         case ($urandom_range(0, 5))
            0: mx = $urandom;
            1: mx = ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
            2: mx = mn - int'($urandom_range(0, 3000));
            default: mx = mn + int'($urandom_range(0, 80000));
         endcase
         nd = ($urandom_range(0, 3) == 0) ? int'($urandom) : int'(ecr_pkg::NODATA_RESET);
         nw = ($urandom_range(0, 3) == 0) ? int'($urandom) : int'(ecr_pkg::NEW_WATER_RESET);
         if ($urandom_range(0, 7) == 0) nw = nd;
         configure(3'($urandom_range(0, 7)), mn, mx, nd, nw);
         for (int i = 0; i < 37; i++) add_sample(pick_elevation(), pick_water());
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Covered %0d requests and %0d colors over %0d register settings.",
               n_requests, n_colors, n_settings);
      $display("Modes exercised (bit per mode): %b, one long output hold-off.", modes_seen);
      if (errors == 0) begin
         $display("** elevation_color_ramp_unit: PASSED **");
      end else begin
         $display("** elevation_color_ramp_unit: FAILED **");
      end
      $finish;
   end
endmodule
